// ===== rtl/core/epp_pkg.sv =====
`timescale 1ns / 1ps
package epp_pkg;

   localparam int MAX_BINS   = 512;
   localparam int COORD_BITS = 12;

   localparam int BIN_BITS = $clog2(MAX_BINS);
   localparam int NB_W     = BIN_BITS + 1;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_INV_BIN_SCALE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_X      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_Y      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_BINS      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COS_ANGLE     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIN_ANGLE     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAJOR_SCALE   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_MINOR_SCALE   = 3'd7;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_PAINT = 1'b1;

   // geometry widths
   localparam int DX_W   = ((COORD_BITS + 9 > 21) ? COORD_BITS + 9 : 21) + 1;
   localparam int PROD_W = DX_W + 16;
   localparam int ROT_W  = PROD_W + 1;
   localparam int MAG_W  = ROT_W;
   localparam int SC_W   = MAG_W + 16;
   localparam int AX_W   = SC_W - 25;
   localparam int SQ_W   = 2 * AX_W;
   localparam int SUM_W  = SQ_W + 1;
   localparam int ROOT_W = (SUM_W + 1) / 2;

   typedef struct packed {
      logic [23:0]        inv_bin_scale;
      logic signed [20:0] center_x;
      logic signed [20:0] center_y;
      logic [NB_W-1:0]    num_bins;
      logic signed [15:0] cos_angle;
      logic signed [15:0] sin_angle;
      logic [15:0]        major_scale;
      logic [15:0]        minor_scale;
   } cfg_type;

   typedef struct packed {
      logic                  mode;
      logic [BIN_BITS-1:0]   bin_index;
      logic signed [31:0]    profile_value;
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic signed [31:0]    pixel_value;
   } req_word_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] out_x;
      logic [COORD_BITS-1:0] out_y;
      logic signed [31:0]    new_value;
   } rsp_word_type;

endpackage

// ===== rtl/core/epp_ram.sv =====
`timescale 1ns / 1ps
module epp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/epp_geom.sv =====
`timescale 1ns / 1ps
module epp_geom (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  epp_pkg::cfg_type            cfg,
   input  logic                        in_valid,
   input  epp_pkg::req_word_type       in_word,
   output logic                        out_valid,
   output epp_pkg::req_word_type       out_word,
   output logic [epp_pkg::SUM_W-1:0]   out_sum
);

   localparam int STAGES   = 9;
   localparam int DX_W     = epp_pkg::DX_W;
   localparam int PROD_W   = epp_pkg::PROD_W;
   localparam int ROT_W    = epp_pkg::ROT_W;
   localparam int MAG_W    = epp_pkg::MAG_W;
   localparam int SC_W     = epp_pkg::SC_W;
   localparam int AX_W     = epp_pkg::AX_W;
   localparam int SQ_W     = epp_pkg::SQ_W;
   localparam int SUM_W    = epp_pkg::SUM_W;
   localparam int AX_SHIFT = 26;

   logic [STAGES-1:0]     valid_ff;
   epp_pkg::req_word_type word_ff [STAGES];

   logic signed [DX_W-1:0]   dx_ff, dy_ff, dx_in, dy_in;
   logic signed [PROD_W-1:0] pcx_ff, psy_ff, psx_ff, pcy_ff;
   logic signed [PROD_W-1:0] pcx_in, psy_in, psx_in, pcy_in;
   logic signed [ROT_W-1:0]  rotx_ff, roty_ff, rotx_in, roty_in;
   logic [MAG_W-1:0]         magx_ff, magy_ff, magx_in, magy_in;
   logic [SC_W-1:0]          scx_ff, scy_ff, scx_in, scy_in;
   logic [AX_W-1:0]          ax_ff, ay_ff, ax_in, ay_in;
   logic [SQ_W-1:0]          sqx_ff, sqy_ff, sqx_in, sqy_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;

   always_comb begin
      dx_in = DX_W'($signed({1'b0, word_ff[0].pixel_x, 8'd0})) - DX_W'(cfg.center_x);
      dy_in = DX_W'($signed({1'b0, word_ff[0].pixel_y, 8'd0})) - DX_W'(cfg.center_y);
      pcx_in = PROD_W'(cfg.cos_angle) * PROD_W'(dx_ff);
      psy_in = PROD_W'(cfg.sin_angle) * PROD_W'(dy_ff);
      psx_in = PROD_W'(cfg.sin_angle) * PROD_W'(dx_ff);
      pcy_in = PROD_W'(cfg.cos_angle) * PROD_W'(dy_ff);
      rotx_in = ROT_W'(pcx_ff) - ROT_W'(psy_ff);
      roty_in = ROT_W'(psx_ff) + ROT_W'(pcy_ff);
      magx_in = MAG_W'(rotx_ff[ROT_W-1] ? -rotx_ff : rotx_ff);
      magy_in = MAG_W'(roty_ff[ROT_W-1] ? -roty_ff : roty_ff);
      scx_in = SC_W'(magx_ff) * SC_W'(cfg.major_scale);
      scy_in = SC_W'(magy_ff) * SC_W'(cfg.minor_scale);
      ax_in = AX_W'(({1'b0, scx_ff} + ((SC_W + 1)'(1) << (AX_SHIFT - 1))) >> AX_SHIFT);
      ay_in = AX_W'(({1'b0, scy_ff} + ((SC_W + 1)'(1) << (AX_SHIFT - 1))) >> AX_SHIFT);
      sqx_in = SQ_W'(ax_ff) * SQ_W'(ax_ff);
      sqy_in = SQ_W'(ay_ff) * SQ_W'(ay_ff);
      sum_in = SUM_W'(sqx_ff) + SUM_W'(sqy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[STAGES-2:0], in_valid};
      end
      if (advance) begin
         word_ff[0] <= in_word;
         for (int s = 1; s < STAGES; s++) begin
            word_ff[s] <= word_ff[s-1];
         end
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         pcx_ff  <= pcx_in;
         psy_ff  <= psy_in;
         psx_ff  <= psx_in;
         pcy_ff  <= pcy_in;
         rotx_ff <= rotx_in;
         roty_ff <= roty_in;
         magx_ff <= magx_in;
         magy_ff <= magy_in;
         scx_ff  <= scx_in;
         scy_ff  <= scy_in;
         ax_ff   <= ax_in;
         ay_ff   <= ay_in;
         sqx_ff  <= sqx_in;
         sqy_ff  <= sqy_in;
         sum_ff  <= sum_in;
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_word  = word_ff[STAGES-1];
   assign out_sum   = sum_ff;

endmodule

// ===== rtl/core/epp_sqrt.sv =====
`timescale 1ns / 1ps
module epp_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  epp_pkg::req_word_type      in_word,
   input  logic [epp_pkg::SUM_W-1:0]  in_value,
   output logic                       out_valid,
   output epp_pkg::req_word_type      out_word,
   output logic [epp_pkg::ROOT_W-1:0] out_root
);

   localparam int STAGES = epp_pkg::ROOT_W;
   localparam int VW     = epp_pkg::SUM_W;
   localparam int RW     = VW + 1;

   logic [STAGES-1:0]     valid_ff;
   epp_pkg::req_word_type word_ff [STAGES];
   logic [VW-1:0]         rem_ff  [STAGES];
   logic [RW-1:0]         root_ff [STAGES];

   logic [VW-1:0] rem_src  [STAGES];
   logic [RW-1:0] root_src [STAGES];
   logic [VW-1:0] rem_in   [STAGES];
   logic [RW-1:0] root_in  [STAGES];

   // one result bit per stage, restoring form
   always_comb begin
      logic [RW-1:0] step_bit;
      logic [RW-1:0] trial;
      for (int s = 0; s < STAGES; s++) begin
         rem_src[s]  = (s == 0) ? in_value : rem_ff[(s == 0) ? 0 : s - 1];
         root_src[s] = (s == 0) ? '0 : root_ff[(s == 0) ? 0 : s - 1];
         step_bit = RW'(1) << (2 * (STAGES - 1 - s));
         trial = root_src[s] + step_bit;
         if ({1'b0, rem_src[s]} >= trial) begin
            rem_in[s]  = rem_src[s] - VW'(trial);
            root_in[s] = (root_src[s] >> 1) + step_bit;
         end else begin
            rem_in[s]  = rem_src[s];
            root_in[s] = root_src[s] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[STAGES-2:0], in_valid};
      end
      if (advance) begin
         word_ff[0] <= in_word;
         for (int s = 1; s < STAGES; s++) begin
            word_ff[s] <= word_ff[s-1];
         end
         for (int s = 0; s < STAGES; s++) begin
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_word  = word_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1][STAGES-1:0];

   // floor root leaves a remainder of at most twice the root
   a_root_floor : assert property (@(posedge clock) disable iff (reset)
      valid_ff[STAGES-1] |-> ({1'b0, rem_ff[STAGES-1]} <= (root_ff[STAGES-1] << 1)))
      else $error("square root remainder out of range");

endmodule

// ===== rtl/core/epp_interp.sv =====
`timescale 1ns / 1ps
module epp_interp (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  epp_pkg::cfg_type           cfg,
   input  logic                       in_valid,
   input  epp_pkg::req_word_type      in_word,
   input  logic [epp_pkg::ROOT_W-1:0] in_root,
   output logic                       out_valid,
   output epp_pkg::rsp_word_type      out_word
);

   localparam int ROOT_W   = epp_pkg::ROOT_W;
   localparam int NB_W     = epp_pkg::NB_W;
   localparam int BIN_BITS = epp_pkg::BIN_BITS;
   localparam int FRAC_W   = 24;
   localparam int RC_W     = ROOT_W + FRAC_W;
   localparam int WC_W     = FRAC_W + 1;
   localparam int P_W      = 32 + WC_W + 1;
   localparam int ACC_W    = P_W + 1;
   localparam int VAL_W    = ACC_W - FRAC_W;
   localparam int SAT_W    = VAL_W + 1;
   localparam logic [RC_W-1:0] HALF_BIN = RC_W'(1) << (FRAC_W - 1);
   localparam logic signed [ACC_W-1:0] ACC_ROUND = ACC_W'(1) << (FRAC_W - 1);
   localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(32'sh7FFF_FFFF);
   localparam logic signed [SAT_W-1:0] SAT_MIN = -SAT_W'(33'sh0_8000_0000);

   logic [6:0] valid_ff;
   epp_pkg::req_word_type word_ff [6];

   logic [RC_W-1:0]   rc_ff, rc_in;
   logic [RC_W-1:0]   rcs;
   logic [ROOT_W-1:0] ri_ff, ri_in;
   logic [FRAC_W-1:0] w2_ff, w2_in, w3_ff, w4_ff;
   logic [NB_W-1:0]   nb;
   logic [NB_W-1:0]   i0_ff, i1_ff, i0_in, i1_in;
   logic [NB_W:0]     i1_wide;
   logic              z0_ff, z1_ff, z0_in, z1_in, z0_4_ff, z1_4_ff;
   logic [31:0]       ram0_data, ram1_data;
   logic              wr_en;
   logic signed [31:0]    t0, t1;
   logic [WC_W-1:0]       wc;
   logic signed [P_W-1:0] p0_ff, p1_ff, p0_in, p1_in;
   logic signed [ACC_W-1:0] acc_rnd;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic signed [SAT_W-1:0] sum;
   epp_pkg::rsp_word_type   out_ff, out_in;

   always_comb begin
      rc_in = RC_W'(in_root) * RC_W'(cfg.inv_bin_scale);
      rcs   = (rc_ff > HALF_BIN) ? rc_ff - HALF_BIN : '0;
      ri_in = rcs[RC_W-1:FRAC_W];
      w2_in = rcs[FRAC_W-1:0];

      nb = (cfg.num_bins > NB_W'(epp_pkg::MAX_BINS)) ? NB_W'(epp_pkg::MAX_BINS)
                                                    : cfg.num_bins;
      i0_in   = (ri_ff < ROOT_W'(nb)) ? NB_W'(ri_ff) : nb;
      i1_wide = {1'b0, i0_in} + (NB_W + 1)'(1);
      i1_in   = (i1_wide < {1'b0, nb}) ? NB_W'(i1_wide) : nb;
      z0_in   = (i0_in == nb);
      z1_in   = (i1_in == nb);

      t0    = z0_4_ff ? 32'sd0 : $signed(ram0_data);
      t1    = z1_4_ff ? 32'sd0 : $signed(ram1_data);
      wc    = (WC_W'(1) << FRAC_W) - WC_W'(w4_ff);
      p0_in = P_W'(t0) * P_W'($signed({1'b0, wc}));
      p1_in = P_W'(t1) * P_W'($signed({2'b0, w4_ff}));

      acc_rnd = ACC_W'(p0_ff) + ACC_W'(p1_ff) + ACC_ROUND;
      val_in  = VAL_W'(acc_rnd >>> FRAC_W);

      sum = SAT_W'(word_ff[5].pixel_value) + SAT_W'(val_ff);
      out_in.out_x = word_ff[5].pixel_x;
      out_in.out_y = word_ff[5].pixel_y;
      if (sum > SAT_MAX) begin
         out_in.new_value = 32'sh7FFF_FFFF;
      end else if (sum < SAT_MIN) begin
         out_in.new_value = 32'sh8000_0000;
      end else begin
         out_in.new_value = 32'(sum);
      end
   end

   // table writes ride the pipeline so loads and paints stay in order
   assign wr_en = advance && valid_ff[2] && (word_ff[2].mode == epp_pkg::MODE_LOAD);

   epp_ram #(.WIDTH(32), .DEPTH(epp_pkg::MAX_BINS)) u_ram_lo (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (word_ff[2].bin_index),
      .wr_data (word_ff[2].profile_value),
      .rd_en   (advance),
      .rd_addr (i0_ff[BIN_BITS-1:0]),
      .rd_data (ram0_data)
   );

   epp_ram #(.WIDTH(32), .DEPTH(epp_pkg::MAX_BINS)) u_ram_hi (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (word_ff[2].bin_index),
      .wr_data (word_ff[2].profile_value),
      .rd_en   (advance),
      .rd_addr (i1_ff[BIN_BITS-1:0]),
      .rd_data (ram1_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff[5:0] <= {valid_ff[4:0], in_valid};
         valid_ff[6]   <= valid_ff[5] && (word_ff[5].mode == epp_pkg::MODE_PAINT);
      end
      if (advance) begin
         word_ff[0] <= in_word;
         for (int s = 1; s < 6; s++) begin
            word_ff[s] <= word_ff[s-1];
         end
         rc_ff   <= rc_in;
         ri_ff   <= ri_in;
         w2_ff   <= w2_in;
         i0_ff   <= i0_in;
         i1_ff   <= i1_in;
         z0_ff   <= z0_in;
         z1_ff   <= z1_in;
         w3_ff   <= w2_ff;
         z0_4_ff <= z0_ff;
         z1_4_ff <= z1_ff;
         w4_ff   <= w3_ff;
         p0_ff   <= p0_in;
         p1_ff   <= p1_in;
         val_ff  <= val_in;
         out_ff  <= out_in;
      end
   end

   assign out_valid = valid_ff[6];
   assign out_word  = out_ff;

   a_index_order : assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> (i1_ff >= i0_ff) && (i1_ff <= nb))
      else $error("upper bin index out of order");

   a_zero_upper : assert property (@(posedge clock) disable iff (reset)
      (valid_ff[2] && z0_ff) |-> z1_ff)
      else $error("lower bin past end but upper bin not");

endmodule

// ===== rtl/core/elliptical_profile_painter_core.sv =====
`timescale 1ns / 1ps
// elliptical radial profile painter
// req channel: req_valid / req_stall / req_word. mode load writes one profile
//   bin, mode paint takes one pixel and its current value.
// rsp channel: rsp_valid / rsp_stall / rsp_word, one word per paint item,
//   in order; load items give no word.
// csr channel: csr_valid / csr_ready / csr_index / csr_wdata, always ready;
//   write registers only while the pipeline is empty.
// throughput: one item per cycle unless rsp_stall holds the pipeline; the datapath is
//   fully pipelined (9 geometry stages, 31 square root stages, 7 lookup and blend
//   stages, 47 register stages in all).
// table: two 512 entry rams with registered read, written from the lookup
//   stage so loads and paints keep their order; entries are undefined until
//   loaded.
// reset: synchronous, clears all stage valids and loads the register defaults;
//   the table is not cleared.
// rsp_stall held high on a valid word freezes every stage and raises
//   req_stall in the same cycle; nothing is lost or repeated.
module elliptical_profile_painter_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  epp_pkg::req_word_type               req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output epp_pkg::rsp_word_type               rsp_word,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [epp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [epp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   epp_pkg::cfg_type cfg_ff;
   logic             advance;

   logic                       geo_valid;
   epp_pkg::req_word_type      geo_word;
   logic [epp_pkg::SUM_W-1:0]  geo_sum;
   logic                       rt_valid;
   epp_pkg::req_word_type      rt_word;
   logic [epp_pkg::ROOT_W-1:0] rt_root;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_bin_scale <= 24'd65536;
         cfg_ff.center_x      <= '0;
         cfg_ff.center_y      <= '0;
         cfg_ff.num_bins      <= epp_pkg::NB_W'(epp_pkg::MAX_BINS);
         cfg_ff.cos_angle     <= 16'sd16384;
         cfg_ff.sin_angle     <= '0;
         cfg_ff.major_scale   <= 16'd4096;
         cfg_ff.minor_scale   <= 16'd4096;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            epp_pkg::CSR_INV_BIN_SCALE: cfg_ff.inv_bin_scale <= csr_wdata[23:0];
            epp_pkg::CSR_CENTER_X:      cfg_ff.center_x      <= csr_wdata[20:0];
            epp_pkg::CSR_CENTER_Y:      cfg_ff.center_y      <= csr_wdata[20:0];
            epp_pkg::CSR_NUM_BINS:      cfg_ff.num_bins      <= csr_wdata[epp_pkg::NB_W-1:0];
            epp_pkg::CSR_COS_ANGLE:     cfg_ff.cos_angle     <= csr_wdata[15:0];
            epp_pkg::CSR_SIN_ANGLE:     cfg_ff.sin_angle     <= csr_wdata[15:0];
            epp_pkg::CSR_MAJOR_SCALE:   cfg_ff.major_scale   <= csr_wdata[15:0];
            epp_pkg::CSR_MINOR_SCALE:   cfg_ff.minor_scale   <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   epp_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg_ff),
      .in_valid  (req_valid && !req_stall),
      .in_word   (req_word),
      .out_valid (geo_valid),
      .out_word  (geo_word),
      .out_sum   (geo_sum)
   );

   epp_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (geo_valid),
      .in_word   (geo_word),
      .in_value  (geo_sum),
      .out_valid (rt_valid),
      .out_word  (rt_word),
      .out_root  (rt_root)
   );

   epp_interp u_interp (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg_ff),
      .in_valid  (rt_valid),
      .in_word   (rt_word),
      .in_root   (rt_root),
      .out_valid (rsp_valid),
      .out_word  (rsp_word)
   );

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a blocked result");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 60;
   localparam int CSR_W        = epp_pkg::CSR_DATA_W;
   localparam int BIN_W        = epp_pkg::BIN_BITS;
   localparam int XY_W         = epp_pkg::COORD_BITS;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   epp_pkg::req_word_type req_word;
   logic                  rsp_valid;
   logic                  rsp_stall;
   epp_pkg::rsp_word_type rsp_word;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [epp_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [epp_pkg::CSR_DATA_W-1:0]  csr_wdata;

   elliptical_profile_painter_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // painter state mirror
   logic [23:0]        m_inv_scale;
   logic signed [20:0] m_cx, m_cy;
   logic [9:0]         m_num_bins;
   logic signed [15:0] m_cos, m_sin;
   logic [15:0]        m_major, m_minor;
   logic signed [31:0] m_profile [epp_pkg::MAX_BINS];
   bit                 loaded [epp_pkg::MAX_BINS];

   epp_pkg::req_word_type pending_words[$];
   epp_pkg::rsp_word_type painted_pixels[$];
   int  errors, cycles, words_sent, pixels_seen, loads_sent;
   int  idle_pct;
   int  hold_asks, hold_seen, hold_left;
   bit  sender_pause;
   bit  took;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'h1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint profile_at(longint unsigned idx, longint unsigned nb);
      if (idx >= nb) return 0;
      return longint'(m_profile[idx]);
   endfunction

   function automatic epp_pkg::rsp_word_type paint_pixel(epp_pkg::req_word_type w);
      epp_pkg::rsp_word_type r;
      longint dx, dy, rotx, roty, t0, t1, acc, val, sum;
      longint unsigned mx, my, ax, ay, rpix, rc, ri, frac, nb, i0, i1;
      dx = longint'({w.pixel_x, 8'h00}) - longint'(m_cx);
      dy = longint'({w.pixel_y, 8'h00}) - longint'(m_cy);
      rotx = longint'(m_cos) * dx - longint'(m_sin) * dy;
      roty = longint'(m_sin) * dx + longint'(m_cos) * dy;
      mx = (rotx < 0) ? -rotx : rotx;
      my = (roty < 0) ? -roty : roty;
      ax = (mx * m_major + (64'h1 << 25)) >> 26;
      ay = (my * m_minor + (64'h1 << 25)) >> 26;
      rpix = int_sqrt(ax * ax + ay * ay);
      rc = rpix * m_inv_scale;
      rc = (rc > (64'h1 << 23)) ? rc - (64'h1 << 23) : 0;
      ri = rc >> 24;
      frac = rc & 64'hFFFFFF;
      nb = (m_num_bins > epp_pkg::MAX_BINS) ? epp_pkg::MAX_BINS : m_num_bins;
      i0 = (ri < nb) ? ri : nb;
      i1 = (i0 + 1 < nb) ? i0 + 1 : nb;
      t0 = profile_at(i0, nb);
      t1 = profile_at(i1, nb);
      acc = t0 * (64'sd16777216 - longint'(frac)) + t1 * longint'(frac);
      val = (acc + 64'sd8388608) >>> 24;
      sum = longint'(w.pixel_value) + val;
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      r.out_x = w.pixel_x;
      r.out_y = w.pixel_y;
      r.new_value = sum[31:0];
      return r;
   endfunction

   // accepted words, csr writes and result checks
   always @(posedge clock) begin
      epp_pkg::rsp_word_type exp_w;
      cycles = cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
      if (!reset && req_valid && !req_stall) begin
         took = 1'b1;
         if (req_word.mode == epp_pkg::MODE_LOAD)
            m_profile[req_word.bin_index] = req_word.profile_value;
         else
            painted_pixels = {painted_pixels, paint_pixel(req_word)};
      end
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            epp_pkg::CSR_INV_BIN_SCALE: m_inv_scale = csr_wdata;
            epp_pkg::CSR_CENTER_X:      m_cx = csr_wdata[20:0];
            epp_pkg::CSR_CENTER_Y:      m_cy = csr_wdata[20:0];
            epp_pkg::CSR_NUM_BINS:      m_num_bins = csr_wdata[9:0];
            epp_pkg::CSR_COS_ANGLE:     m_cos = csr_wdata[15:0];
            epp_pkg::CSR_SIN_ANGLE:     m_sin = csr_wdata[15:0];
            epp_pkg::CSR_MAJOR_SCALE:   m_major = csr_wdata[15:0];
            epp_pkg::CSR_MINOR_SCALE:   m_minor = csr_wdata[15:0];
            default: ;
         endcase
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         pixels_seen = pixels_seen + 1;
         if (painted_pixels.size() == 0) begin
            errors = errors + 1;
            $error("unexpected word x=%0d y=%0d", rsp_word.out_x, rsp_word.out_y);
         end else begin
            exp_w = painted_pixels.pop_front();
            if (rsp_word.out_x !== exp_w.out_x) begin
               errors = errors + 1;
               $error("out_x expected %0d actual %0d", exp_w.out_x, rsp_word.out_x);
            end
            if (rsp_word.out_y !== exp_w.out_y) begin
               errors = errors + 1;
               $error("out_y expected %0d actual %0d", exp_w.out_y, rsp_word.out_y);
            end
            if (rsp_word.new_value !== exp_w.new_value) begin
               errors = errors + 1;
               $error("new_value expected %0d actual %0d",
                      exp_w.new_value, rsp_word.new_value);
            end
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (!reset && (!req_valid || took)) begin
         took = 1'b0;
         if (pending_words.size() > 0 && !sender_pause &&
             $urandom_range(99) >= idle_pct) begin
            req_word <= pending_words.pop_front();
            req_valid <= 1'b1;
            words_sent = words_sent + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall
   always @(negedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   task automatic csr_write(input logic [epp_pkg::CSR_INDEX_W-1:0] idx, input int data);
      @(negedge clock);
      csr_index <= idx;
      csr_wdata <= CSR_W'(data);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_words.size() > 0 || req_valid || painted_pixels.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_load(input int idx, input logic [31:0] v);
      epp_pkg::req_word_type w;
      w = '0;
      w.mode = epp_pkg::MODE_LOAD;
      w.bin_index = BIN_W'(idx);
      w.profile_value = v;
      w.pixel_x = XY_W'($urandom);
      w.pixel_y = XY_W'($urandom);
      w.pixel_value = $urandom;
      loaded[idx] = 1'b1;
      loads_sent = loads_sent + 1;
      pending_words = {pending_words, w};
   endtask

   task automatic add_pixel(input int x, input int y, input logic [31:0] v);
      epp_pkg::req_word_type w;
      w = '0;
      w.mode = epp_pkg::MODE_PAINT;
      w.bin_index = BIN_W'($urandom);
      w.profile_value = $urandom;
      w.pixel_x = XY_W'(x);
      w.pixel_y = XY_W'(y);
      w.pixel_value = v;
      pending_words = {pending_words, w};
   endtask

   function automatic int loaded_prefix();
      int n;
      n = 0;
      while (n < epp_pkg::MAX_BINS && loaded[n]) n = n + 1;
      return n;
   endfunction

   function automatic int pick(input int lo, input int hi);
      int r;
      r = $urandom_range(3);
      if (r == 0) return lo;
      if (r == 1) return hi;
      return int'($urandom_range(hi - lo)) + lo;
   endfunction

   function automatic int near(input int c);
      int p;
      p = c + int'($urandom_range(80)) - 40;
      if (p < 0) p = 0;
      if (p > 4095) p = 4095;
      return p;
   endfunction

   initial begin
      int top, nb, next_bin, cx_pix, cy_pix;
      logic [31:0] r32;
      req_valid = 1'b0;
      req_word = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      errors = 0; cycles = 0; words_sent = 0; pixels_seen = 0; loads_sent = 0;
      idle_pct = 20; hold_asks = 0; hold_seen = 0; hold_left = 0;
      sender_pause = 1'b0; took = 1'b0;
      m_inv_scale = 24'd65536; m_cx = '0; m_cy = '0; m_num_bins = 10'd512;
      m_cos = 16'sd16384; m_sin = '0; m_major = 16'd4096; m_minor = 16'd4096;
      foreach (m_profile[i]) begin
         m_profile[i] = '0;
         loaded[i] = 1'b0;
      end
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero bins: pixels pass through
      csr_write(epp_pkg::CSR_NUM_BINS, 24'd0);
      add_pixel(0, 0, 32'h7fffffff);
      add_pixel(4095, 4095, 32'h80000000);
      add_load(0, 32'h7fffffff);
      add_load(1, 32'h80000000);
      add_load(2, 32'h00010000);
      add_load(511, 32'hdeadbeef);
      drain();
      csr_write(epp_pkg::CSR_NUM_BINS, 24'd3);
      add_pixel(0, 0, 32'h7fffffff);
      add_pixel(0, 0, 32'h00000000);
      add_pixel(1, 0, 32'h00000000);
      add_pixel(2, 0, 32'h80000000);
      add_pixel(0, 3, 32'h12345678);
      add_pixel(4095, 0, 32'h00000000);
      add_pixel(4095, 4095, 32'h7fffffff);
      add_load(0, 32'hffff0000);
      add_pixel(0, 0, 32'h80000000);
      drain();

      next_bin = 3;
      for (int ph = 0; ph < 20; ph++) begin
         idle_pct = (ph >= 8 && ph <= 10) ? 0 : 20;
         top = loaded_prefix();
         if (ph == 0 || $urandom_range(1)) csr_write(epp_pkg::CSR_INV_BIN_SCALE,
            (ph == 0) ? 24'd0 : (ph == 19) ? 24'hffffff : pick(0, 24'hffffff));
         if (ph == 0 || $urandom_range(1)) csr_write(epp_pkg::CSR_CENTER_X,
            (ph == 1) ? -1048576 : (ph == 2) ? 1048575 : pick(-1048576, 1048575));
         if (ph == 0 || $urandom_range(1)) csr_write(epp_pkg::CSR_CENTER_Y,
            (ph == 1) ? 1048575 : (ph == 2) ? -1048576 : pick(-1048576, 1048575));
         nb = $urandom_range(top);
         if (top == epp_pkg::MAX_BINS && $urandom_range(1)) nb = $urandom_range(1023, 512);
         if (ph == 19) nb = 1023;
         csr_write(epp_pkg::CSR_NUM_BINS, nb);
         if (ph == 0 || $urandom_range(1))
            csr_write(epp_pkg::CSR_COS_ANGLE, pick(-16384, 16384));
         if (ph == 0 || $urandom_range(1))
            csr_write(epp_pkg::CSR_SIN_ANGLE, pick(-16384, 16384));
         if (ph == 0 || $urandom_range(1)) csr_write(epp_pkg::CSR_MAJOR_SCALE,
            (ph == 3) ? 0 : (ph == 4) ? 65535 : pick(0, 65535));
         if (ph == 0 || $urandom_range(1)) csr_write(epp_pkg::CSR_MINOR_SCALE,
            (ph == 3) ? 65535 : (ph == 4) ? 0 : pick(0, 65535));
         if (ph == 0 || $urandom_range(3) == 0)
            csr_write(epp_pkg::CSR_INV_BIN_SCALE, $urandom_range(1 << 17));
         cx_pix = int'(m_cx) >>> 8;
         cy_pix = int'(m_cy) >>> 8;

         // every bin is loaded before the last phase
         for (int k = 0; k < 27 && next_bin < epp_pkg::MAX_BINS; k++) begin
            add_load(next_bin, $urandom);
            next_bin = next_bin + 1;
         end
         if (ph == 5 || ph == 14) hold_asks = hold_asks + 1;
         for (int k = 0; k < 30; k++) begin
            r32 = $urandom;
            case ($urandom_range(7))
               0, 1:    add_load($urandom_range(511), r32);
               2:       add_pixel($urandom_range(4095), $urandom_range(4095), r32);
               default: add_pixel(near(cx_pix), near(cy_pix), r32);
            endcase
         end
         while (pending_words.size() > 15) @(posedge clock);
         // pause until all painted words are back
         sender_pause = 1'b1;
         while (painted_pixels.size() > 0 || req_valid) @(posedge clock);
         sender_pause = 1'b0;
         drain();
      end

      $display("%0d words sent (%0d loads), %0d painted pixels checked",
               words_sent, loads_sent, pixels_seen);
      $display("covered zero, partial and saturated bin counts, rotations and stalls");
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== elliptical_profile_painter_core.f =====
rtl/core/epp_pkg.sv
rtl/core/epp_ram.sv
rtl/core/epp_geom.sv
rtl/core/epp_sqrt.sv
rtl/core/epp_interp.sv
rtl/core/elliptical_profile_painter_core.sv
tb/sv/tb_top.sv
